// File: src/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

    // fixed width of the root outputs
    localparam int ROOT_W  = 34;
    localparam int COUNT_W = 2;

    // root count codes
    localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;

    // coefficient flags out of the discriminant stages
    typedef struct packed {
        logic lead_zero;
        logic a_neg;
    } t_coef_flags;

    // flags that ride along through the square root and divider pipes
    typedef struct packed {
        logic lead_zero;
        logic a_neg;
        logic disc_neg;
        logic disc_zero;
    } t_flags;

endpackage

`default_nettype wire

// File: src/quadratic_root_solver.sv
`default_nettype none

// Real roots of a*x^2 + b*x + c in fixed point with FRAC_BITS fraction bits.
// Fully pipelined: a new coefficient beat is taken every cycle while the pipe
// is not held, and each beat returns one result. The depth is set by the
// square root pipe, one root bit per stage (COEF_WIDTH+FRAC_BITS+1 bits), and
// the two restoring dividers, one quotient bit per stage
// (COEF_WIDTH+FRAC_BITS+3 bits). The whole pipe holds while a result waits on
// o_out_valid with i_out_stall high. A zero leading coefficient gives
// o_leading_zero_error with count and roots at zero; a negative discriminant
// gives count zero and zero roots. Roots are truncated toward zero and
// saturate to 34 bits.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_a,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_b,
    input  wire logic signed [COEF_WIDTH-1:0] i_coef_c,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [COUNT_W-1:0]                o_root_count,
    output logic signed [ROOT_W-1:0]          o_root_plus,
    output logic signed [ROOT_W-1:0]          o_root_minus,
    output logic                              o_leading_zero_error
);

    localparam int CW    = COEF_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int DW    = 2 * CW + 2;
    localparam int NBW   = CW + FB + 1;
    localparam int DENW  = CW + 1;
    localparam int RT_W  = CW + FB + 1;
    localparam int NW    = CW + FB + 3;
    localparam int FLW   = $bits(t_flags);
    localparam int SQ_SB = NBW + DENW + FLW;
    localparam int EW    = NW + ROOT_W;
    localparam logic signed [EW-1:0] RMAX = {{(EW-ROOT_W+1){1'b0}}, {(ROOT_W-1){1'b1}}};
    localparam logic signed [EW-1:0] RMIN = ~RMAX;

    logic adv;

    // discriminant stages
    logic                   d_valid;
    logic signed [DW-1:0]   d_disc;
    logic signed [NBW-1:0]  d_nb;
    logic [DENW-1:0]        d_den;
    t_coef_flags            d_cflags;

    // square root pipe signals
    t_flags                 d_flags;
    logic [2*RT_W-1:0]      d_rad;
    logic                   s_valid;
    logic [RT_W-1:0]        s_root;
    logic [SQ_SB-1:0]       s_sb;
    logic signed [NBW-1:0]  s_nb;
    logic [DENW-1:0]        s_den;
    t_flags                 s_flags;

    // sum stage
    logic                   r_sum_vld;
    logic signed [NW-1:0]   r_nump, r_numm;
    logic [DENW-1:0]        r_den;
    t_flags                 r_flags;

    // divider signals
    logic [NW-1:0]          mag_p, mag_m;
    logic                   sgn_p, sgn_m;
    logic                   q_valid;
    logic [NW-1:0]          q_p, q_m;
    logic [FLW:0]           q_sb_p;
    logic                   q_sb_m;
    t_flags                 q_flags;
    logic                   q_neg_p, q_neg_m;

    // output register
    logic                   r_o_valid;
    logic [COUNT_W-1:0]     r_count;
    logic signed [ROOT_W-1:0] r_plus, r_minus;
    logic                   r_lzero;
    logic [COUNT_W-1:0]     n_count;
    logic signed [ROOT_W-1:0] n_plus, n_minus;

    // whole pipe moves unless a finished beat is held
    assign adv        = !(r_o_valid && i_out_stall);
    assign o_in_stall = !adv;

    qrs_disc #(.CW(CW), .FB(FB)) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_a     (i_coef_a),
        .i_b     (i_coef_b),
        .i_c     (i_coef_c),
        .o_valid (d_valid),
        .o_disc  (d_disc),
        .o_nb    (d_nb),
        .o_den   (d_den),
        .o_flags (d_cflags)
    );

    // radicand is the discriminant scaled by 2^(2*FB), zero when negative
    always_comb begin
        d_flags.lead_zero = d_cflags.lead_zero;
        d_flags.a_neg     = d_cflags.a_neg;
        d_flags.disc_neg  = d_disc[DW-1];
        d_flags.disc_zero = (d_disc == '0);
        d_rad = d_disc[DW-1] ? '0 : ((2*RT_W)'(d_disc[DW-2:0]) << (2 * FB));
    end

    qrs_sqrt #(.RT_W(RT_W), .SB_W(SQ_SB)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (d_valid),
        .i_rad   (d_rad),
        .i_sb    ({d_nb, d_den, d_flags}),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_sb    (s_sb)
    );

    assign {s_nb, s_den, s_flags} = s_sb;

    // numerators for both branches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
        end else if (adv) begin
            r_sum_vld <= s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_nump  <= NW'(s_nb) + $signed(NW'(s_root));
            r_numm  <= NW'(s_nb) - $signed(NW'(s_root));
            r_den   <= s_den;
            r_flags <= s_flags;
        end
    end

    // magnitudes and quotient signs
    always_comb begin
        mag_p = r_nump[NW-1] ? NW'(-r_nump) : NW'(r_nump);
        mag_m = r_numm[NW-1] ? NW'(-r_numm) : NW'(r_numm);
        sgn_p = r_nump[NW-1] ^ r_flags.a_neg;
        sgn_m = r_numm[NW-1] ^ r_flags.a_neg;
    end

    qrs_div #(.NUM_W(NW), .DEN_W(DENW), .SB_W(FLW+1)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_sum_vld),
        .i_num   (mag_p),
        .i_den   (r_den),
        .i_sb    ({r_flags, sgn_p}),
        .o_valid (q_valid),
        .o_quo   (q_p),
        .o_sb    (q_sb_p)
    );

    qrs_div #(.NUM_W(NW), .DEN_W(DENW), .SB_W(1)) u_div_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_sum_vld),
        .i_num   (mag_m),
        .i_den   (r_den),
        .i_sb    (sgn_m),
        .o_valid (),
        .o_quo   (q_m),
        .o_sb    (q_sb_m)
    );

    assign {q_flags, q_neg_p} = q_sb_p;
    assign q_neg_m            = q_sb_m;

    // sign, saturation and masking of special cases
    always_comb begin
        logic signed [EW-1:0] vp, vm;
        vp = q_neg_p ? -$signed(EW'(q_p)) : $signed(EW'(q_p));
        vm = q_neg_m ? -$signed(EW'(q_m)) : $signed(EW'(q_m));
        if (vp > RMAX)      n_plus = RMAX[ROOT_W-1:0];
        else if (vp < RMIN) n_plus = RMIN[ROOT_W-1:0];
        else                n_plus = vp[ROOT_W-1:0];
        if (vm > RMAX)      n_minus = RMAX[ROOT_W-1:0];
        else if (vm < RMIN) n_minus = RMIN[ROOT_W-1:0];
        else                n_minus = vm[ROOT_W-1:0];
        if (q_flags.lead_zero || q_flags.disc_neg) begin
            n_count = CNT_NONE;
            n_plus  = '0;
            n_minus = '0;
        end else if (q_flags.disc_zero) begin
            n_count = CNT_ONE;
        end else begin
            n_count = CNT_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_count <= n_count;
            r_plus  <= n_plus;
            r_minus <= n_minus;
            r_lzero <= q_flags.lead_zero;
        end
    end

    assign o_out_valid          = r_o_valid;
    assign o_root_count         = r_count;
    assign o_root_plus          = r_plus;
    assign o_root_minus         = r_minus;
    assign o_leading_zero_error = r_lzero;

    // a zero leading coefficient reports no roots
    a_lzero_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_leading_zero_error) |->
            (o_root_count == CNT_NONE && o_root_plus == '0 && o_root_minus == '0))
        else $error("leading zero result not cleared");

    // a double root shows the same value twice
    a_double_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_root_count == CNT_ONE) |-> (o_root_plus == o_root_minus))
        else $error("double root branches differ");

    // no roots means zero root fields
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_root_count == CNT_NONE) |->
            (o_root_plus == '0 && o_root_minus == '0))
        else $error("roots reported without real roots");

    // the pipe holds exactly while a finished beat waits
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("held result dropped");

endmodule

`default_nettype wire

// File: src/qrs_disc.sv
`default_nettype none

module qrs_disc
    import qrs_pkg::*;
#(
    parameter int CW = 16,
    parameter int FB = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic signed [CW-1:0]     i_a,
    input  wire logic signed [CW-1:0]     i_b,
    input  wire logic signed [CW-1:0]     i_c,
    output logic                          o_valid,
    output logic signed [2*CW+1:0]        o_disc,
    output logic signed [CW+FB:0]         o_nb,
    output logic        [CW:0]            o_den,
    output t_coef_flags                   o_flags
);

    localparam int DW  = 2 * CW + 2;
    localparam int NBW = CW + FB + 1;

    logic [2:0]              r_vld;
    logic signed [CW-1:0]    r1_a, r1_b, r1_c;
    logic signed [2*CW-1:0]  r_bb, r_ac;
    logic signed [CW-1:0]    r2_a, r2_b;
    logic signed [DW-1:0]    r_disc;
    logic signed [NBW-1:0]   r_nb;
    logic [CW:0]             r_den;
    t_coef_flags             r_flags;

    logic signed [DW-1:0]    n_disc;
    logic signed [NBW-1:0]   n_nb;
    logic [CW-1:0]           a_abs;
    t_coef_flags             n_flags;

    // discriminant, negated b scaled to fixed point, and 2|a|
    always_comb begin
        n_disc = DW'(r_bb) - (DW'(r_ac) <<< 2);
        n_nb   = -(NBW'(r2_b) <<< FB);
        a_abs  = r2_a[CW-1] ? CW'(-r2_a) : CW'(r2_a);
        n_flags.lead_zero = (r2_a == '0);
        n_flags.a_neg     = r2_a[CW-1];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    // payload stages: capture, products, difference
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a    <= i_a;
            r1_b    <= i_b;
            r1_c    <= i_c;
            r_bb    <= r1_b * r1_b;
            r_ac    <= r1_a * r1_c;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r_disc  <= n_disc;
            r_nb    <= n_nb;
            r_den   <= {a_abs, 1'b0};
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_vld[2];
    assign o_disc  = r_disc;
    assign o_nb    = r_nb;
    assign o_den   = r_den;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

// File: src/qrs_sqrt.sv
`default_nettype none

module qrs_sqrt #(
    parameter int RT_W = 33,
    parameter int SB_W = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [2*RT_W-1:0]   i_rad,
    input  wire logic [SB_W-1:0]     i_sb,
    output logic                     o_valid,
    output logic [RT_W-1:0]          o_root,
    output logic [SB_W-1:0]          o_sb
);

    localparam int XW = 2 * RT_W;
    localparam int RW = RT_W + 2;

    logic [RT_W:0]            r_vld;
    logic [XW-1:0]            r_rad  [RT_W+1];
    logic [RW-1:0]            r_rem  [RT_W+1];
    logic [RT_W-1:0]          r_root [RT_W+1];
    logic [SB_W-1:0]          r_sb   [RT_W+1];

    logic [XW-1:0]            n_rad  [RT_W];
    logic [RW-1:0]            n_rem  [RT_W];
    logic [RT_W-1:0]          n_root [RT_W];

    // one result bit per stage: bring down a bit pair and try 4*root+1
    always_comb begin
        logic [RW+1:0] sh;
        logic [RW+1:0] trial;
        for (int i = 0; i < RT_W; i++) begin
            sh    = {r_rem[i], r_rad[i][XW-1 -: 2]};
            trial = (RW+2)'({r_root[i], 2'b01});
            n_rad[i] = r_rad[i] << 2;
            if (sh >= trial) begin
                n_rem[i]  = RW'(sh - trial);
                n_root[i] = {r_root[i][RT_W-2:0], 1'b1};
            end else begin
                n_rem[i]  = RW'(sh);
                n_root[i] = {r_root[i][RT_W-2:0], 1'b0};
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RT_W-1:0], i_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_sb[0]   <= i_sb;
            for (int i = 0; i < RT_W; i++) begin
                r_rad[i+1]  <= n_rad[i];
                r_rem[i+1]  <= n_rem[i];
                r_root[i+1] <= n_root[i];
                r_sb[i+1]   <= r_sb[i];
            end
        end
    end

    assign o_valid = r_vld[RT_W];
    assign o_root  = r_root[RT_W];
    assign o_sb    = r_sb[RT_W];

endmodule

`default_nettype wire

// File: src/qrs_div.sv
`default_nettype none

module qrs_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 17,
    parameter int SB_W  = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]   i_den,
    input  wire logic [SB_W-1:0]    i_sb,
    output logic                    o_valid,
    output logic [NUM_W-1:0]        o_quo,
    output logic [SB_W-1:0]         o_sb
);

    logic [NUM_W:0]          r_vld;
    logic [NUM_W-1:0]        r_num [NUM_W+1];
    logic [NUM_W-1:0]        r_quo [NUM_W+1];
    logic [DEN_W-1:0]        r_rem [NUM_W+1];
    logic [DEN_W-1:0]        r_den [NUM_W+1];
    logic [SB_W-1:0]         r_sb  [NUM_W+1];

    logic [NUM_W-1:0]        n_quo [NUM_W];
    logic [DEN_W-1:0]        n_rem [NUM_W];

    // restoring division, one quotient bit per stage
    always_comb begin
        logic [DEN_W:0] sh;
        logic           ge;
        for (int i = 0; i < NUM_W; i++) begin
            sh = {r_rem[i], r_num[i][NUM_W-1]};
            ge = (sh >= {1'b0, r_den[i]});
            n_rem[i] = ge ? DEN_W'(sh - {1'b0, r_den[i]}) : DEN_W'(sh);
            n_quo[i] = {r_quo[i][NUM_W-2:0], ge};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-1:0], i_valid};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num;
            r_quo[0] <= '0;
            r_rem[0] <= '0;
            r_den[0] <= i_den;
            r_sb[0]  <= i_sb;
            for (int i = 0; i < NUM_W; i++) begin
                r_num[i+1] <= r_num[i] << 1;
                r_quo[i+1] <= n_quo[i];
                r_rem[i+1] <= n_rem[i];
                r_den[i+1] <= r_den[i];
                r_sb[i+1]  <= r_sb[i];
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quo   = r_quo[NUM_W];
    assign o_sb    = r_sb[NUM_W];

endmodule

`default_nettype wire
